/* hw/rtl/hrm_pkg.sv */
// Package: types, constants and helpers for the homogeneous rotation matrix core.
`default_nettype none
package hrm_pkg;
   localparam int ANGLE_BITS    = 16;
   localparam int FRACTION_BITS = 14;
   localparam int CORDIC_STEPS  = 30;
   localparam int ZW            = 33;
   localparam int XW            = 34;

   typedef struct packed {
      logic                   three_d;
      logic signed [15:0]     angle_a;
      logic signed [15:0]     angle_b;
      logic signed [15:0]     angle_c;
   } req_type;

   typedef struct packed {
      logic [1:0]         row;
      logic signed [15:0] entry_0;
      logic signed [15:0] entry_1;
      logic signed [15:0] entry_2;
      logic signed [15:0] entry_3;
      logic               last;
   } rsp_type;

   typedef logic signed [XW-1:0] q30_type;

   function automatic logic signed [ZW-1:0] atan_turn(input logic [4:0] i);
      logic signed [ZW-1:0] r;
      r = '0;
      unique case (i)
         5'd0: r = 33'sd536870912;  5'd1: r = 33'sd316933406;
         5'd2: r = 33'sd167458907;  5'd3: r = 33'sd85004756;
         5'd4: r = 33'sd42667331;   5'd5: r = 33'sd21354465;
         5'd6: r = 33'sd10679838;   5'd7: r = 33'sd5340245;
         5'd8: r = 33'sd2670163;    5'd9: r = 33'sd1335086;
         5'd10: r = 33'sd667544;    5'd11: r = 33'sd333772;
         5'd12: r = 33'sd166886;    5'd13: r = 33'sd83443;
         5'd14: r = 33'sd41722;     5'd15: r = 33'sd20861;
         5'd16: r = 33'sd10430;     5'd17: r = 33'sd5215;
         5'd18: r = 33'sd2608;      5'd19: r = 33'sd1304;
         5'd20: r = 33'sd652;       5'd21: r = 33'sd326;
         5'd22: r = 33'sd163;       5'd23: r = 33'sd81;
         5'd24: r = 33'sd41;        5'd25: r = 33'sd20;
         5'd26: r = 33'sd10;        5'd27: r = 33'sd5;
         5'd28: r = 33'sd3;         5'd29: r = 33'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

   // Q30 product with round half up (floor shift).
   function automatic q30_type mul_q30(input q30_type u, input q30_type v);
      logic signed [2*XW-1:0] p;
      p = u * v + (68'sd1 <<< 29);
      return q30_type'(p >>> 30);
   endfunction

   // Q30 to output format with saturation.
   function automatic logic [15:0] out_entry(input q30_type v);
      localparam int S = 30 - FRACTION_BITS;
      logic signed [XW-1:0] r;
      logic signed [XW-1:0] lim;
      lim = q30_type'(1) <<< FRACTION_BITS;
      r = (v + (q30_type'(1) <<< (S - 1))) >>> S;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r[15:0];
   endfunction
endpackage
`default_nettype wire

/* hw/rtl/hrm_cordic.sv */
// Pipelined CORDIC sine/cosine, one step per stage.
`default_nettype none
module hrm_cordic
   import hrm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic [ANGLE_BITS-1:0] angle,
   output q30_type                    sin_out,
   output q30_type                    cos_out
);
   q30_type              x_ff [0:CORDIC_STEPS];
   q30_type              y_ff [0:CORDIC_STEPS];
   logic signed [ZW-1:0] z_ff [0:CORDIC_STEPS];
   logic                 f_ff [0:CORDIC_STEPS];
   logic [31:0]          a_in;
   logic                 flip_in;
   logic [31:0]          af_in;

   always_comb begin
      a_in    = {angle, {(32 - ANGLE_BITS){1'b0}}};
      flip_in = a_in[31] ^ a_in[30];
      af_in   = flip_in ? (a_in - 32'h8000_0000) : a_in;
   end

   always_ff @(posedge clock) begin
      x_ff[0] <= q30_type'(652032874);
      y_ff[0] <= '0;
      z_ff[0] <= {af_in[31], af_in};
      f_ff[0] <= flip_in;
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (!z_ff[i][ZW-1]) begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - atan_turn(5'(i));
         end else begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + atan_turn(5'(i));
         end
         f_ff[i+1] <= f_ff[i];
      end
   end

   assign sin_out = f_ff[CORDIC_STEPS] ? -y_ff[CORDIC_STEPS] : y_ff[CORDIC_STEPS];
   assign cos_out = f_ff[CORDIC_STEPS] ? -x_ff[CORDIC_STEPS] : x_ff[CORDIC_STEPS];
endmodule
`default_nettype wire

/* hw/rtl/hrm_matrix.sv */
// Product pipeline forming the rotation matrix entries.
`default_nettype none
module hrm_matrix
   import hrm_pkg::*;
(
   input  wire logic clock,
   input  q30_type   sa, ca, sb, cb, sc, cc,
   output q30_type   m00, m01, m02, m10, m11, m12, m20, m21, m22
);
   q30_type cacb_ff, cbcc_ff, cbsa_ff, sasc_ff, ccsa_ff, casc_ff, cacc_ff;
   q30_type casb_ff, sasb_ff, ccsb_ff, sbsc_ff;
   q30_type sa_ff, cb_ff, sc_ff, cc_ff;
   q30_type t0_ff, t1_ff, t2_ff, t3_ff;
   q30_type a0_ff, a1_ff, a2_ff, a3_ff, b02_ff, b12_ff, b20_ff, b21_ff, b22_ff;

   always_ff @(posedge clock) begin
      cacb_ff <= mul_q30(ca, cb);  cbcc_ff <= mul_q30(cb, cc);
      cbsa_ff <= mul_q30(cb, sa);  sasc_ff <= mul_q30(sa, sc);
      ccsa_ff <= mul_q30(cc, sa);  casc_ff <= mul_q30(ca, sc);
      cacc_ff <= mul_q30(ca, cc);  casb_ff <= mul_q30(ca, sb);
      sasb_ff <= mul_q30(sa, sb);  ccsb_ff <= mul_q30(cc, sb);
      sbsc_ff <= mul_q30(sb, sc);
      sa_ff <= sa; cb_ff <= cb; sc_ff <= sc; cc_ff <= cc;
      // second products
      t0_ff <= mul_q30(cacb_ff, cc_ff);
      t1_ff <= mul_q30(cacb_ff, sc_ff);
      t2_ff <= mul_q30(cbcc_ff, sa_ff);
      t3_ff <= mul_q30(cbsa_ff, sc_ff);
      a0_ff <= sasc_ff; a1_ff <= ccsa_ff; a2_ff <= casc_ff; a3_ff <= cacc_ff;
      b02_ff <= -casb_ff; b12_ff <= -sasb_ff;
      b20_ff <= ccsb_ff;  b21_ff <= -sbsc_ff; b22_ff <= cb_ff;
      // sums
      m00 <= t0_ff - a0_ff;
      m01 <= -a1_ff - t1_ff;
      m10 <= a2_ff + t2_ff;
      m11 <= a3_ff - t3_ff;
      m02 <= b02_ff; m12 <= b12_ff;
      m20 <= b20_ff; m21 <= b21_ff; m22 <= b22_ff;
   end
endmodule
`default_nettype wire

/* hw/rtl/homogeneous_rotation_matrix_core.sv */
// Top level: homogeneous rotation matrix core.
// An item is taken when start is high and busy low; busy stays high after
// each transfer, so no new item is taken until busy falls again. Results
// pass through 31 CORDIC stages, three product/sum stages and one output
// stage, then come out one row per cycle: three rows in planar
// mode, four in spatial mode, marked by rsp_valid and rsp_data.last on the
// final row. The receiver cannot stall; every row is held for exactly one cycle.
`default_nettype none
module homogeneous_rotation_matrix_core
   import hrm_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic      busy,
   input  req_type   req_data,
   output logic      rsp_valid,
   output rsp_type   rsp_data
);
   localparam int LAT = CORDIC_STEPS + 1 + 3;

   logic [1:0]   gap_ff;
   logic         take;
   q30_type      sa, ca, sb, cb, sc, cc;
   q30_type      m00, m01, m02, m10, m11, m12, m20, m21, m22;
   logic [LAT-1:0] v_ff;
   logic [LAT-1:0] m_ff;
   q30_type      ca_d_ff [0:2];
   q30_type      sa_d_ff [0:2];
   q30_type      hold_ff [0:8];
   logic         mode_ff;
   logic [1:0]   row_ff;
   logic         act_ff;
   logic         fire;

   assign busy = gap_ff != 2'd0;
   assign take = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) gap_ff <= 2'd0;
      else if (take) gap_ff <= 2'd3;
      else if (busy) gap_ff <= gap_ff - 2'd1;
   end

   hrm_cordic u_ca (.clock, .angle(req_data.angle_a[ANGLE_BITS-1:0]), .sin_out(sa), .cos_out(ca));
   hrm_cordic u_cb (.clock, .angle(req_data.angle_b[ANGLE_BITS-1:0]), .sin_out(sb), .cos_out(cb));
   hrm_cordic u_cc (.clock, .angle(req_data.angle_c[ANGLE_BITS-1:0]), .sin_out(sc), .cos_out(cc));

   hrm_matrix u_mat (.clock, .sa, .ca, .sb, .cb, .sc, .cc,
      .m00, .m01, .m02, .m10, .m11, .m12, .m20, .m21, .m22);

   // match planar entries to matrix latency
   always_ff @(posedge clock) begin
      ca_d_ff[0] <= ca; sa_d_ff[0] <= sa;
      for (int k = 1; k < 3; k++) begin
         ca_d_ff[k] <= ca_d_ff[k-1]; sa_d_ff[k] <= sa_d_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else v_ff <= {v_ff[LAT-2:0], take};
      m_ff <= {m_ff[LAT-2:0], req_data.three_d};
   end

   assign fire = v_ff[LAT-1];

   // row sequencer: capture one matrix and play rows out
   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
         row_ff <= 2'd0;
      end else if (fire) begin
         act_ff <= 1'b1;
         row_ff <= 2'd0;
      end else if (act_ff) begin
         if ((mode_ff && row_ff == 2'd3) || (!mode_ff && row_ff == 2'd2))
            act_ff <= 1'b0;
         row_ff <= row_ff + 2'd1;
      end
      if (fire) begin
         mode_ff <= m_ff[LAT-1];
         if (m_ff[LAT-1]) begin
            hold_ff[0] <= m00; hold_ff[1] <= m01; hold_ff[2] <= m02;
            hold_ff[3] <= m10; hold_ff[4] <= m11; hold_ff[5] <= m12;
            hold_ff[6] <= m20; hold_ff[7] <= m21; hold_ff[8] <= m22;
         end else begin
            hold_ff[0] <= ca_d_ff[2]; hold_ff[1] <= -sa_d_ff[2]; hold_ff[2] <= '0;
            hold_ff[3] <= sa_d_ff[2]; hold_ff[4] <= ca_d_ff[2];  hold_ff[5] <= '0;
            hold_ff[6] <= '0; hold_ff[7] <= '0; hold_ff[8] <= '0;
         end
      end
   end

   always_comb begin
      rsp_valid        = act_ff;
      rsp_data.row     = row_ff;
      rsp_data.entry_0 = '0;
      rsp_data.entry_1 = '0;
      rsp_data.entry_2 = '0;
      rsp_data.entry_3 = '0;
      rsp_data.last    = 1'b0;
      unique case (row_ff)
         2'd0: begin
            rsp_data.entry_0 = out_entry(hold_ff[0]);
            rsp_data.entry_1 = out_entry(hold_ff[1]);
            rsp_data.entry_2 = out_entry(hold_ff[2]);
         end
         2'd1: begin
            rsp_data.entry_0 = out_entry(hold_ff[3]);
            rsp_data.entry_1 = out_entry(hold_ff[4]);
            rsp_data.entry_2 = out_entry(hold_ff[5]);
         end
         2'd2: begin
            rsp_data.entry_0 = out_entry(hold_ff[6]);
            rsp_data.entry_1 = out_entry(hold_ff[7]);
            rsp_data.entry_2 = mode_ff ? out_entry(hold_ff[8])
                                       : out_entry(q30_type'(1) <<< 30);
            rsp_data.last    = !mode_ff;
         end
         2'd3: begin
            rsp_data.entry_3 = out_entry(q30_type'(1) <<< 30);
            rsp_data.last    = 1'b1;
         end
         default: ;
      endcase
   end
endmodule
`default_nettype wire
